@@ rtl/psh_pkg.sv @@
// Shared types, sizes and codes of the pair-sum hash finder.
// Used by every module under rtl/ but psh_ram; depends on nothing else.
`timescale 1ns / 1ps

package psh_pkg;

  localparam int VAL_W       = 32;
  localparam int MAX_ITEMS   = 512;
  // must be a power of two: probe addresses wrap at the index width
  localparam int TABLE_SLOTS = 1024;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int STPOS_W     = $clog2(MAX_ITEMS);
  localparam int PCNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int SCNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int POS_W       = 9;
  localparam int STATUS_W    = 2;
  localparam int EPOCH_W     = 8;
  localparam int QDEPTH      = 2;
  localparam int HASH_CHUNKS = (VAL_W + IDX_W - 1) / IDX_W;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int ADDR_W      = 3;

  // register index, taken from paddr[2]
  localparam logic REG_TARGET_SUM = 1'b0;

  localparam logic [STATUS_W-1:0] STAT_NO_MATCH   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MATCH      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SET_DONE   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_STORED = 2'd3;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] need;
    logic             need_ok;
    logic [IDX_W-1:0] h_need;
    logic [IDX_W-1:0] h_val;
  } item_t;

  // tag 0 marks an empty slot; live slots carry the current epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [STPOS_W-1:0] pos;
    logic [VAL_W-1:0]   val;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // status sits in the low bits
  typedef struct packed {
    logic [POS_W-1:0]    second_position;
    logic [POS_W-1:0]    first_position;
    logic [STATUS_W-1:0] status;
  } res_t;

  function automatic logic [IDX_W-1:0] slot_hash(input logic [VAL_W-1:0] v);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < HASH_CHUNKS; i++) begin
      h ^= IDX_W'(v >> (i * IDX_W));
    end
    return h;
  endfunction

endpackage

@@ rtl/psh_ram.sv @@
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module psh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/psh_fifo.sv @@
// Short item queue between the front and the back of the finder.
// Depends on psh_pkg (item_t, QDEPTH).
`timescale 1ns / 1ps

module psh_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  psh_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output psh_pkg::item_t rd_item
);

  localparam int PTR_W = (psh_pkg::QDEPTH > 1) ? $clog2(psh_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(psh_pkg::QDEPTH + 1);

  psh_pkg::item_t   slots [psh_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(psh_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_item;
        wr_ptr <= (wr_ptr == PTR_W'(psh_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(psh_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/psh_front.sv @@
// Front end: takes input transfers, works out the partner value and both
// hash indexes, and queues the item. Depends on psh_pkg and psh_fifo.
`timescale 1ns / 1ps

module psh_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [psh_pkg::VAL_W-1:0] target_sum,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_start,
  input  logic [psh_pkg::VAL_W-1:0] in_value,
  output logic                      q_valid,
  input  logic                      q_ready,
  output psh_pkg::item_t            q_item
);

  logic [psh_pkg::VAL_W:0] need_wide;
  psh_pkg::item_t          item;

  // exact difference at one extra bit; fits 32 bits when the top two agree
  assign need_wide = {target_sum[psh_pkg::VAL_W-1], target_sum}
                   - {in_value[psh_pkg::VAL_W-1], in_value};

  always_comb begin
    item.start   = in_start;
    item.value   = in_value;
    item.need    = need_wide[psh_pkg::VAL_W-1:0];
    item.need_ok = (need_wide[psh_pkg::VAL_W] == need_wide[psh_pkg::VAL_W-1]);
    item.h_need  = psh_pkg::slot_hash(need_wide[psh_pkg::VAL_W-1:0]);
    item.h_val   = psh_pkg::slot_hash(in_value);
  end

  psh_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_item  (item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

endmodule

@@ rtl/psh_back.sv @@
// Back end: hash table sequencer with linear probing, epoch-tagged slots,
// set bookkeeping and the result register. Depends on psh_pkg and psh_ram.
`timescale 1ns / 1ps

module psh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  psh_pkg::item_t q_item,
  output logic           m_valid,
  input  logic           m_ready,
  output psh_pkg::res_t  m_res
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    DISPATCH,
    PROBE_NEED,
    PROBE_VAL,
    FINISH
  } state_t;

  localparam logic [psh_pkg::EPOCH_W-1:0] EPOCH_FIRST = psh_pkg::EPOCH_W'(1);
  localparam logic [psh_pkg::EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [psh_pkg::IDX_W-1:0]   IDX_LAST    =
    psh_pkg::IDX_W'(psh_pkg::TABLE_SLOTS - 1);

  state_t                        state;
  psh_pkg::item_t                item;
  logic [psh_pkg::PCNT_W-1:0]    pos_cnt;
  logic                          matched;
  logic [psh_pkg::SCNT_W-1:0]    stored_cnt;
  logic [psh_pkg::EPOCH_W-1:0]   epoch;
  logic [psh_pkg::IDX_W-1:0]     probe_addr;
  logic [psh_pkg::IDX_W-1:0]     probe_cnt;
  logic [psh_pkg::IDX_W-1:0]     clr_addr;
  logic                          resume;
  psh_pkg::res_t                 res;

  logic                          ram_en;
  logic                          ram_we;
  logic [psh_pkg::IDX_W-1:0]     ram_addr;
  psh_pkg::slot_t                ram_wslot;
  logic [psh_pkg::SLOT_W-1:0]    ram_rdata;
  psh_pkg::slot_t                rd_slot;

  logic live;
  logic need_hit;
  logic val_hit;
  logic probe_last;

  assign rd_slot    = psh_pkg::slot_t'(ram_rdata);
  assign live       = (rd_slot.tag == epoch);
  assign need_hit   = live && (rd_slot.val == item.need);
  assign val_hit    = live && (rd_slot.val == item.value);
  assign probe_last = (probe_cnt == IDX_LAST);
  assign q_ready    = (state == IDLE);

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = probe_addr + 1'b1;
    ram_wslot = '0;
    case (state)
      CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      DISPATCH: begin
        ram_en   = 1'b1;
        ram_addr = item.need_ok ? item.h_need : item.h_val;
      end
      PROBE_NEED: begin
        ram_en = 1'b1;
        if (!live || probe_last) begin
          ram_addr = item.h_val;
        end
      end
      PROBE_VAL: begin
        ram_en = 1'b1;
        if (!live) begin
          ram_we        = 1'b1;
          ram_addr      = probe_addr;
          ram_wslot.tag = epoch;
          ram_wslot.pos = psh_pkg::STPOS_W'(pos_cnt);
          ram_wslot.val = item.value;
        end
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  psh_ram #(
    .WIDTH (psh_pkg::SLOT_W),
    .DEPTH (psh_pkg::TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wslot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      pos_cnt    <= '0;
      matched    <= 1'b0;
      stored_cnt <= '0;
      epoch      <= EPOCH_FIRST;
      clr_addr   <= '0;
      resume     <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      if (m_valid && m_ready && state != FINISH) begin
        m_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_LAST) begin
            state <= resume ? DISPATCH : IDLE;
          end
        end
        IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            state <= DISPATCH;
            if (q_item.start) begin
              pos_cnt    <= '0;
              matched    <= 1'b0;
              stored_cnt <= '0;
              // tags would wrap onto stale slots: sweep the table first
              if (epoch == EPOCH_LAST) begin
                epoch    <= EPOCH_FIRST;
                clr_addr <= '0;
                resume   <= 1'b1;
                state    <= CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end
          end
        end
        DISPATCH: begin
          resume    <= 1'b0;
          probe_cnt <= '0;
          if (matched) begin
            res   <= psh_pkg::res_t'({{(2 * psh_pkg::POS_W){1'b0}},
                                      psh_pkg::STAT_SET_DONE});
            state <= FINISH;
          end else if (pos_cnt >= psh_pkg::PCNT_W'(psh_pkg::MAX_ITEMS)) begin
            res   <= psh_pkg::res_t'({{(2 * psh_pkg::POS_W){1'b0}},
                                      psh_pkg::STAT_NOT_STORED});
            state <= FINISH;
          end else if (item.need_ok) begin
            res        <= '0;
            probe_addr <= item.h_need;
            state      <= PROBE_NEED;
          end else begin
            res        <= '0;
            probe_addr <= item.h_val;
            state      <= PROBE_VAL;
          end
        end
        PROBE_NEED: begin
          if (need_hit) begin
            res     <= psh_pkg::res_t'({psh_pkg::POS_W'(pos_cnt),
                                        psh_pkg::POS_W'(rd_slot.pos),
                                        psh_pkg::STAT_MATCH});
            matched <= 1'b1;
            pos_cnt <= pos_cnt + 1'b1;
            state   <= FINISH;
          end else if (!live || probe_last) begin
            probe_addr <= item.h_val;
            probe_cnt  <= '0;
            state      <= PROBE_VAL;
          end else begin
            probe_addr <= probe_addr + 1'b1;
            probe_cnt  <= probe_cnt + 1'b1;
          end
        end
        PROBE_VAL: begin
          if (val_hit) begin
            pos_cnt <= pos_cnt + 1'b1;
            state   <= FINISH;
          end else if (!live) begin
            // empty slot: the value goes in here
            stored_cnt <= stored_cnt + 1'b1;
            pos_cnt    <= pos_cnt + 1'b1;
            state      <= FINISH;
          end else if (probe_last) begin
            res.status <= psh_pkg::STAT_NOT_STORED;
            pos_cnt    <= pos_cnt + 1'b1;
            state      <= FINISH;
          end else begin
            probe_addr <= probe_addr + 1'b1;
            probe_cnt  <= probe_cnt + 1'b1;
          end
        end
        FINISH: begin
          if (!m_valid || m_ready) begin
            m_valid <= 1'b1;
            m_res   <= res;
            state   <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch tag collides with the empty mark");

  a_no_probe_after_match: assert property (@(posedge clk) disable iff (rst)
    (state == PROBE_NEED || state == PROBE_VAL) |-> !matched)
    else $error("table probed in a set that already matched");

  a_stored_le_pos: assert property (@(posedge clk) disable iff (rst)
    psh_pkg::SCNT_W'(stored_cnt) <= psh_pkg::SCNT_W'(pos_cnt) ||
    psh_pkg::SCNT_W < psh_pkg::PCNT_W)
    else $error("more values stored than positions used");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos_cnt <= psh_pkg::PCNT_W'(psh_pkg::MAX_ITEMS))
    else $error("position counter ran past the set limit");

  a_pop_moves_on: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && q_valid) |=> (state == DISPATCH || state == CLEAR))
    else $error("queued item taken but not dispatched");

endmodule

@@ rtl/pair_sum_hash_finder.sv @@
// Top level of the pair-sum hash finder: stream ports, register port,
// front end and back end. Depends on psh_pkg, psh_front and psh_back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: value[31:0]; tuser: start_of_set
//  m_*      out  m_tvalid/m_tready  tdata: status, first_position,
//                                          second_position, zero pad
//  apb      in   psel/penable/      target_sum at byte address 0
//                pwrite, pready=1
//
// A full lookup walks the partner's and then the value's hash chain by linear
// probing in the single-port table; the partner chain is skipped when the
// partner is out of range, the value chain when the partner is found, and both
// in a matched or overlong set. After reset, and once every 255 sets, a sweep
// clears the table tags, during which no item is taken. Two items queue behind
// the sequencer and a result waits in its own register, so either side may stall.
`timescale 1ns / 1ps

module pair_sum_hash_finder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [psh_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic [0:0]                      s_tuser,   // [0] start_of_set
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [10:2] first_position, [19:11] second_position, [23:20] 0
  output logic [psh_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psh_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [psh_pkg::VAL_W-1:0] target_sum;
  logic                      q_valid;
  logic                      q_ready;
  psh_pkg::item_t            q_item;
  psh_pkg::res_t             m_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == psh_pkg::REG_TARGET_SUM) ? target_sum : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == psh_pkg::REG_TARGET_SUM) begin
      target_sum <= pwdata;
    end
  end

  psh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .target_sum (target_sum),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_start   (s_tuser[0]),
    .in_value   (s_tdata),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  psh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res)
  );

  assign m_tdata = {{(psh_pkg::OUT_TDATA_W - $bits(psh_pkg::res_t)){1'b0}}, m_res};

endmodule
